@@ hdl/json_stream_parser_defines.svh @@
// ---------------------------------------------------------------------------
// json_stream_parser_defines: assertion macros
// Shared macros for concurrent checks on the parser ports.
// ---------------------------------------------------------------------------
`ifndef JSON_STREAM_PARSER_DEFINES_SVH
`define JSON_STREAM_PARSER_DEFINES_SVH

// Implication checked on every edge outside reset.
`define JSP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define JSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/jsp_pkg.sv @@
// ---------------------------------------------------------------------------
// jsp_pkg: shared types and codes
// Event codes, error codes, parse modes and the event record.
// ---------------------------------------------------------------------------
package jsp_pkg;

	localparam int DefStackDepth = 64;

	localparam logic [3:0] EV_OPEN_OBJ = 4'd0;
	localparam logic [3:0] EV_OPEN_ARR = 4'd1;
	localparam logic [3:0] EV_CLOSE    = 4'd2;
	localparam logic [3:0] EV_KEY_BYTE = 4'd3;
	localparam logic [3:0] EV_KEY_END  = 4'd4;
	localparam logic [3:0] EV_STR_BYTE = 4'd5;
	localparam logic [3:0] EV_STR_END  = 4'd6;
	localparam logic [3:0] EV_NULL     = 4'd7;
	localparam logic [3:0] EV_BOOL     = 4'd8;
	localparam logic [3:0] EV_INT      = 4'd9;
	localparam logic [3:0] EV_FLOAT    = 4'd10;
	localparam logic [3:0] EV_ERROR    = 4'd11;
	localparam logic [3:0] EV_DONE     = 4'd12;

	localparam logic [3:0] ER_SECOND_ROOT = 4'd0;
	localparam logic [3:0] ER_MISMATCH    = 4'd1;
	localparam logic [3:0] ER_UNEXPECTED  = 4'd2;
	localparam logic [3:0] ER_CTRL_CHAR   = 4'd3;
	localparam logic [3:0] ER_BAD_UNICODE = 4'd4;
	localparam logic [3:0] ER_BAD_ESCAPE  = 4'd5;
	localparam logic [3:0] ER_MISS_NAME   = 4'd6;
	localparam logic [3:0] ER_UNKNOWN_ID  = 4'd7;
	localparam logic [3:0] ER_BAD_INT     = 4'd8;
	localparam logic [3:0] ER_BAD_FLOAT   = 4'd9;
	localparam logic [3:0] ER_UNCLOSED    = 4'd10;
	localparam logic [3:0] ER_EMPTY       = 4'd11;
	localparam logic [3:0] ER_OVERFLOW    = 4'd12;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_STR  = 3'd1;
	localparam logic [2:0] M_ESC  = 3'd2;
	localparam logic [2:0] M_HEX  = 3'd3;
	localparam logic [2:0] M_LITN = 3'd4;
	localparam logic [2:0] M_LITT = 3'd5;
	localparam logic [2:0] M_LITF = 3'd6;
	localparam logic [2:0] M_NUM  = 3'd7;

	typedef struct packed {
		logic [3:0]  ev;
		logic [7:0]  data;
		logic [31:0] ival;
		logic        bval;
		logic [3:0]  err;
		logic [6:0]  depth;
	} event_t;

	// Letter i of literal w (null, true, false).
	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (w)
			2'd0: case (i)
				3'd0: r = "n"; 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l";
				default: r = 8'h00;
			endcase
			2'd1: case (i)
				3'd0: r = "t"; 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e";
				default: r = 8'h00;
			endcase
			default: case (i)
				3'd0: r = "f"; 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s";
				3'd4: r = "e";
				default: r = 8'h00;
			endcase
		endcase
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
	endfunction

endpackage

@@ hdl/jsp_core.sv @@
// ---------------------------------------------------------------------------
// jsp_core: parser state and event builder
// Consumes one registered byte per cycle while step is high and produces up to three events.
// ---------------------------------------------------------------------------
module jsp_core #(
	parameter int StackDepth = jsp_pkg::DefStackDepth
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             ch,
	input  logic                   eot,
	output jsp_pkg::event_t [2:0]  evs,
	output logic [1:0]             n_evs
);
	import jsp_pkg::*;

	localparam int LvlW = $clog2(StackDepth + 1);
	localparam int IdxW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

	logic              stack_q [StackDepth];
	logic [LvlW-1:0]   level_q, level_d;
	logic [2:0]        mode_q, mode_d;
	logic              keyp_q, keyp_d, iskey_q, iskey_d, root_q, root_d;
	logic [2:0]        lidx_q, lidx_d;
	logic [15:0]       hex_q, hex_d;
	logic [31:0]       acc_q, acc_d;
	logic [5:0]        flg_q, flg_d;
	logic              err_q, err_d;
	logic              push_en;
	logic              pop_en;
	logic              push_val;

	// Top entry and the one below it live in registers; the stack array is
	// only read on a pop, to refill the entry below, with registered data.
	logic              top_q, top_d;
	logic              below_q;
	logic              top_obj;
	logic [IdxW-1:0]   below_idx;

	assign below_idx = IdxW'(level_q - LvlW'(3));
	assign top_obj   = (level_q != '0) && top_q;

	always_ff @(posedge clk) begin
		if (step && push_en) begin
			stack_q[level_q[IdxW-1:0]] <= push_val;
			below_q <= top_q;
		end else if (step && pop_en) begin
			below_q <= stack_q[below_idx];
		end
	end

	always_comb begin
		event_t     e;
		logic [1:0] n;
		logic [7:0] d;
		logic [3:0] hd;
		logic       hok;
		logic [15:0] cp;
		logic [1:0] ph;
		logic       bad;
		logic [1:0] w;
		logic [2:0] llen;
		logic       go_idle;
		logic       num_err;
		logic [31:0] v;
		level_d = level_q; mode_d = mode_q; keyp_d = keyp_q; iskey_d = iskey_q;
		root_d = root_q; lidx_d = lidx_q; hex_d = hex_q; acc_d = acc_q;
		flg_d = flg_q; err_d = err_q; top_d = top_q;
		push_en = 1'b0; pop_en = 1'b0; push_val = 1'b0;
		evs = '0; n = 2'd0; e = '0; d = 8'h00; hd = 4'h0; hok = 1'b0; cp = 16'h0;
		ph = flg_q[5:4]; bad = 1'b0; w = 2'd0; llen = 3'd4; go_idle = 1'b0;
		num_err = 1'b0; v = 32'h0;

		// number finish (used by end of text and delimiters)
		if (flg_q[1]) begin
			num_err = flg_q[2];
		end else begin
			num_err = flg_q[3];
		end
		v = flg_q[0] ? (32'h0 - acc_q) : acc_q;

		if (eot) begin
			if (!err_q) begin
				e.depth = 7'(level_q);
				unique case (mode_q) inside
					M_STR: begin e.ev = EV_ERROR; e.err = ER_UNCLOSED; evs[0] = e; n = 2'd1; end
					M_ESC: begin e.ev = EV_ERROR; e.err = ER_BAD_ESCAPE; evs[0] = e; n = 2'd1; end
					M_HEX: begin e.ev = EV_ERROR; e.err = ER_BAD_UNICODE; evs[0] = e; n = 2'd1; end
					M_LITN, M_LITT, M_LITF: begin
						e.ev = EV_ERROR; e.err = ER_UNKNOWN_ID; evs[0] = e; n = 2'd1;
					end
					default: begin
						if (mode_q == M_NUM) begin
							if (num_err) begin
								e.ev = EV_ERROR; e.err = flg_q[1] ? ER_BAD_FLOAT : ER_BAD_INT;
							end else if (flg_q[1]) begin
								e.ev = EV_FLOAT;
							end else begin
								e.ev = EV_INT; e.ival = v;
							end
							evs[0] = e; n = 2'd1;
						end
						if (!(mode_q == M_NUM && num_err)) begin
							e = '0; e.depth = 7'(level_q);
							if (level_q != '0) begin
								e.ev = EV_ERROR; e.err = ER_UNCLOSED;
							end else if (!root_q) begin
								e.ev = EV_ERROR; e.err = ER_EMPTY;
							end else begin
								e.ev = EV_DONE;
							end
							evs[n] = e; n = n + 2'd1;
						end
					end
				endcase
			end
			level_d = '0; mode_d = M_IDLE; keyp_d = 1'b0; iskey_d = 1'b0; root_d = 1'b0;
			lidx_d = '0; hex_d = '0; acc_d = '0; flg_d = '0; err_d = 1'b0;
		end else if (!err_q) begin
			e.depth = 7'(level_q);
			unique case (mode_q) inside
				M_STR: begin
					if (ch < 8'h20) begin
						e.ev = EV_ERROR; e.err = ER_CTRL_CHAR; err_d = 1'b1;
						evs[0] = e; n = 2'd1;
					end else if (ch == "\\") begin
						mode_d = M_ESC;
					end else if (ch == "\"") begin
						mode_d = M_IDLE; keyp_d = iskey_q;
						e.ev = iskey_q ? EV_KEY_END : EV_STR_END; evs[0] = e; n = 2'd1;
					end else begin
						e.ev = iskey_q ? EV_KEY_BYTE : EV_STR_BYTE; e.data = ch;
						evs[0] = e; n = 2'd1;
					end
				end
				M_ESC: begin
					hok = 1'b1;
					case (ch)
						"\"", "\\", "/": d = ch;
						"b": d = 8'h08;
						"f": d = 8'h0C;
						"n": d = 8'h0A;
						"r": d = 8'h0D;
						"t": d = 8'h09;
						"u": hok = 1'b0;
						default: begin
							hok = 1'b0;
							e.ev = EV_ERROR; e.err = ER_BAD_ESCAPE; err_d = 1'b1;
							evs[0] = e; n = 2'd1;
						end
					endcase
					if (ch == "u") begin
						mode_d = M_HEX; lidx_d = '0; hex_d = '0;
					end else if (hok) begin
						mode_d = M_STR;
						e.ev = iskey_q ? EV_KEY_BYTE : EV_STR_BYTE; e.data = d;
						evs[0] = e; n = 2'd1;
					end
				end
				M_HEX: begin
					hok = 1'b1;
					if (ch >= "0" && ch <= "9") hd = 4'(ch - "0");
					else if (ch >= "a" && ch <= "f") hd = 4'(ch - "a" + 8'd10);
					else if (ch >= "A" && ch <= "F") hd = 4'(ch - "A" + 8'd10);
					else hok = 1'b0;
					if (!hok) begin
						e.ev = EV_ERROR; e.err = ER_BAD_UNICODE; err_d = 1'b1;
						evs[0] = e; n = 2'd1;
					end else begin
						cp = {hex_q[11:0], hd};
						hex_d = cp;
						lidx_d = lidx_q + 3'd1;
						if (lidx_q + 3'd1 >= 3'd4) begin
							mode_d = M_STR; lidx_d = '0;
							e.ev = iskey_q ? EV_KEY_BYTE : EV_STR_BYTE;
							if (cp <= 16'h7F) begin
								e.data = cp[7:0]; evs[0] = e; n = 2'd1;
							end else if (cp <= 16'h7FF) begin
								e.data = 8'hC0 | 8'(cp[10:6]); evs[0] = e;
								e.data = 8'h80 | {2'b00, cp[5:0]}; evs[1] = e; n = 2'd2;
							end else begin
								e.data = 8'hE0 | {4'h0, cp[15:12]}; evs[0] = e;
								e.data = 8'h80 | {2'b00, cp[11:6]}; evs[1] = e;
								e.data = 8'h80 | {2'b00, cp[5:0]}; evs[2] = e; n = 2'd3;
							end
						end
					end
				end
				M_LITN, M_LITT, M_LITF: begin
					w = 2'(mode_q - M_LITN);
					llen = (w == 2'd2) ? 3'd5 : 3'd4;
					if (lidx_q >= llen || ch != lit_char(w, lidx_q)) begin
						e.ev = EV_ERROR; e.err = ER_UNKNOWN_ID; err_d = 1'b1;
						evs[0] = e; n = 2'd1;
					end else begin
						lidx_d = lidx_q + 3'd1;
						if (lidx_q + 3'd1 >= llen) begin
							mode_d = M_IDLE; lidx_d = '0;
							if (w == 2'd0) begin
								e.ev = EV_NULL;
							end else begin
								e.ev = EV_BOOL; e.bval = (w == 2'd1);
							end
							evs[0] = e; n = 2'd1;
						end
					end
				end
				M_NUM: begin
					if (is_ws(ch) || ch == "," || ch == "]" || ch == "}") begin
						mode_d = M_IDLE;
						if (num_err) begin
							e.ev = EV_ERROR; e.err = flg_q[1] ? ER_BAD_FLOAT : ER_BAD_INT;
							err_d = 1'b1;
						end else if (flg_q[1]) begin
							e.ev = EV_FLOAT;
						end else begin
							e.ev = EV_INT; e.ival = v;
						end
						evs[0] = e; n = 2'd1;
						go_idle = !num_err;
					end else begin
						flg_d[3:0] = flg_q[3:0];
						if (ch >= "0" && ch <= "9") begin
							acc_d = acc_q * 32'd10 + 32'(ch - "0");
							if (ph == 2'd2) ph = 2'd3;
						end else begin
							flg_d[3] = 1'b1;
							if (ch == ".") begin
								flg_d[1] = 1'b1;
								if (ph == 2'd0) ph = 2'd1; else bad = 1'b1;
							end else if (ch == "e" || ch == "E") begin
								flg_d[1] = 1'b1;
								if (ph <= 2'd1) ph = 2'd2; else bad = 1'b1;
							end else if (ch == "+" || ch == "-") begin
								if (ph == 2'd2) ph = 2'd3; else bad = 1'b1;
							end else begin
								bad = 1'b1;
							end
						end
						if (bad) flg_d[2] = 1'b1;
						flg_d[5:4] = ph;
					end
				end
				default: go_idle = 1'b1;
			endcase

			if (go_idle) begin
				mode_d = M_IDLE;
				e = '0; e.depth = 7'(level_q);
				if (is_ws(ch)) begin
				end else if (ch == "{" || ch == "[") begin
					if (level_q == '0 && root_q) begin
						e.ev = EV_ERROR; e.err = ER_SECOND_ROOT; err_d = 1'b1;
					end else if (level_q >= LvlW'(StackDepth)) begin
						e.ev = EV_ERROR; e.err = ER_OVERFLOW; err_d = 1'b1;
					end else begin
						if (level_q == '0) root_d = 1'b1;
						push_en = 1'b1; push_val = (ch == "{"); top_d = (ch == "{");
						level_d = level_q + LvlW'(1); keyp_d = 1'b0;
						e.ev = (ch == "{") ? EV_OPEN_OBJ : EV_OPEN_ARR;
						e.depth = 7'(level_q + LvlW'(1));
					end
					evs[n] = e; n = n + 2'd1;
				end else if (ch == "}" || ch == "]") begin
					if (level_q == '0 || top_obj != (ch == "}")) begin
						e.ev = EV_ERROR; e.err = ER_MISMATCH; err_d = 1'b1;
					end else begin
						pop_en = 1'b1; top_d = below_q;
						level_d = level_q - LvlW'(1);
						e.ev = EV_CLOSE; e.depth = 7'(level_q - LvlW'(1));
					end
					evs[n] = e; n = n + 2'd1;
				end else if (ch == ":") begin
					if (!top_obj || !keyp_q) begin
						e.ev = EV_ERROR; e.err = ER_UNEXPECTED; err_d = 1'b1;
						evs[n] = e; n = n + 2'd1;
					end
				end else if (ch == "," || ch == "\"") begin
					if (level_q == '0) begin
						e.ev = EV_ERROR; e.err = ER_UNEXPECTED; err_d = 1'b1;
						evs[n] = e; n = n + 2'd1;
					end else if (ch == "\"") begin
						iskey_d = !keyp_q && top_obj; mode_d = M_STR;
					end
				end else if (ch == "n" || ch == "t" || ch == "f" || ch == "-" ||
						(ch >= "0" && ch <= "9")) begin
					if (level_q == '0) begin
						e.ev = EV_ERROR; e.err = ER_UNEXPECTED; err_d = 1'b1;
						evs[n] = e; n = n + 2'd1;
					end else if (top_obj && !keyp_q) begin
						e.ev = EV_ERROR; e.err = ER_MISS_NAME; err_d = 1'b1;
						evs[n] = e; n = n + 2'd1;
					end else begin
						keyp_d = 1'b0;
						if (ch == "n") begin
							mode_d = M_LITN; lidx_d = 3'd1;
						end else if (ch == "t") begin
							mode_d = M_LITT; lidx_d = 3'd1;
						end else if (ch == "f") begin
							mode_d = M_LITF; lidx_d = 3'd1;
						end else begin
							mode_d = M_NUM;
							flg_d = (ch == "-") ? 6'h01 : 6'h00;
							acc_d = (ch == "-") ? 32'h0 : 32'(ch - "0");
						end
					end
				end else begin
					e.ev = EV_ERROR; e.err = ER_UNEXPECTED; err_d = 1'b1;
					evs[n] = e; n = n + 2'd1;
				end
			end
		end
		n_evs = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0; mode_q <= M_IDLE; keyp_q <= 1'b0; iskey_q <= 1'b0;
			root_q <= 1'b0; lidx_q <= '0; hex_q <= '0; acc_q <= '0; flg_q <= '0;
			err_q <= 1'b0; top_q <= 1'b0;
		end else if (step) begin
			level_q <= level_d; mode_q <= mode_d; keyp_q <= keyp_d; iskey_q <= iskey_d;
			root_q <= root_d; lidx_q <= lidx_d; hex_q <= hex_d; acc_q <= acc_d;
			flg_q <= flg_d; err_q <= err_d; top_q <= top_d;
		end
	end

endmodule

@@ hdl/jsp_out_queue.sv @@
// ---------------------------------------------------------------------------
// jsp_out_queue: event output buffer
// Holds up to three events from one byte and drains them one per cycle while pop is high.
// ---------------------------------------------------------------------------
module jsp_out_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  jsp_pkg::event_t [2:0] evs,
	input  logic [1:0]            n_evs,
	input  logic                  pop,
	output logic                  empty_next,
	output logic                  nonempty,
	output jsp_pkg::event_t       head
);
	import jsp_pkg::*;

	event_t [2:0] buf_q;
	logic [1:0]   cnt_q;

	assign nonempty   = cnt_q != 2'd0;
	assign head       = buf_q[0];
	assign empty_next = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_evs;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= evs;
		end else if (pop) begin
			buf_q <= {buf_q[2], buf_q[2], buf_q[1]};
		end
	end

endmodule

@@ hdl/json_stream_parser.sv @@
// ---------------------------------------------------------------------------
// json_stream_parser: streaming JSON tokenizer
// Byte stream in, SAX-style event words out.
// ---------------------------------------------------------------------------
//  channel | dir | tdata fields (lsb up)                 | tuser
//  s_axis  | in  | ch[7:0]                                | end_of_text
//  m_axis  | out | event_res,data_byte,num_value,         | -
//          |     | bool_value,error_code,nest_depth (56b) |
//
// One input word enters a register; the parser consumes it once the output
// buffer will be empty and loads all its events (zero to three) into it.
// A word that makes one or zero events streams at one word per cycle while
// m_axis is ready; a word with more events holds the input while the buffer
// drains. Stalls on m_axis propagate back through s_axis_tready.
// Reset clears all parser state; stack contents are written before read.
module json_stream_parser #(
	parameter int StackDepth = jsp_pkg::DefStackDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // ch
	input  logic        s_axis_tuser,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata    // event_res,data_byte,num_value,bool_value,error_code,nest_depth
);
	import jsp_pkg::*;

	logic            full_s1;
	logic [7:0]      ch_s1;
	logic            eot_s1;
	event_t [2:0]    evs;
	logic [1:0]      n_evs;
	logic            pop, empty_next, nonempty, step;
	event_t          head;

	assign pop  = m_axis_tvalid && m_axis_tready;
	// consume the staged word once the buffer will be empty
	assign step = full_s1 && empty_next;
	assign s_axis_tready = !full_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			full_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1  <= s_axis_tdata;
			eot_s1 <= s_axis_tuser;
		end
	end

	jsp_core #(.StackDepth(StackDepth)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .ch(ch_s1), .eot(eot_s1),
		.evs(evs), .n_evs(n_evs)
	);

	jsp_out_queue u_queue (
		.clk(clk), .arst_n(arst_n), .load(step), .evs(evs), .n_evs(n_evs),
		.pop(pop), .empty_next(empty_next), .nonempty(nonempty), .head(head)
	);

	assign m_axis_tvalid = nonempty;
	assign m_axis_tdata  = {head.depth, head.err, head.bval, head.ival, head.data, head.ev};

endmodule

@@ hdl/jsp_checker.sv @@
// ---------------------------------------------------------------------------
// jsp_checker: port checks
// Stream rules and event range checks seen at the top-level ports.
// ---------------------------------------------------------------------------
`include "json_stream_parser_defines.svh"

module jsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);
	`JSP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
	`JSP_ASSERT(a_in_stall, s_axis_tvalid && !s_axis_tready, m_axis_tvalid, "input stalled with no output pending")
	`JSP_ASSERT(a_ev_range, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd12, "event code out of range")
	`JSP_ASSERT(a_err_range, m_axis_tvalid, m_axis_tdata[48:45] <= 4'd12, "error code out of range")
	`JSP_ASSERT(a_depth, m_axis_tvalid, m_axis_tdata[55:49] <= 7'd64, "depth out of range")
endmodule

bind json_stream_parser jsp_checker u_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
